>>> hdl/assert_macros.svh
// assertion macros used by the top-level rtl file of the first-position search block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// plain property checked on every clock edge out of reset
`define FPAL_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("fpal assertion failed");
// same-cycle implication
`define FPAL_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fpal assertion failed");
// next-cycle implication
`define FPAL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fpal assertion failed");
`else
`define FPAL_ASSERT(lbl, prop)
`define FPAL_ASSERT_IMPL(lbl, ante, cons)
`define FPAL_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> hdl/fpal_pkg.sv
// types and constants shared by the first-position search block
package fpal_pkg;

	// field widths
	localparam int POS_W = 11;
	localparam int VAL_W = 32;

	// defaults
	localparam int TABLE_DEPTH_DEF = 1024;
	localparam logic [POS_W-1:0] SIZE_RESET = 11'd1024;

	// opcode values
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	// one tree node: any leaf below written, and max of the written leaves
	typedef struct packed {
		logic                    written;
		logic signed [VAL_W-1:0] value;
	} node_t;

	// datapath operations
	typedef enum logic [3:0] {
		DP_IDLE,
		DP_LOAD,
		DP_CLEAR,
		DP_WR_LEAF,
		DP_RD_SIB,
		DP_WR_PARENT,
		DP_RD_NODE,
		DP_UP,
		DP_RD_NEXT,
		DP_RD_LEFT,
		DP_DESCEND,
		DP_SET_FOUND,
		DP_SET_NONE
	} dp_op_t;

	// controller to datapath
	typedef struct packed {
		dp_op_t op;
		logic   emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic is_search;
		logic range_ok;
		logic at_root;
		logic node_odd;
		logic at_leaf;
		logic qualifies;
	} sts_t;

	// controller states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECIDE,
		ST_W_UP,
		ST_W_MERGE,
		ST_S_CHECK,
		ST_S_CLIMB,
		ST_S_DOWN,
		ST_S_DESC,
		ST_EMIT
	} state_t;

endpackage

>>> hdl/fpal_datapath.sv
// datapath: max tree memory, node walker, size register and result registers
module fpal_datapath #(
	parameter int TABLE_DEPTH = fpal_pkg::TABLE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fpal_pkg::cmd_t                      cmd,
	output fpal_pkg::sts_t                      sts,
	input  logic                                opcode,
	input  logic [fpal_pkg::POS_W-1:0]          position,
	input  logic signed [fpal_pkg::VAL_W-1:0]   amount,
	input  logic                                write_enable,
	input  logic [fpal_pkg::POS_W-1:0]          write_data,
	output logic                                found,
	output logic [fpal_pkg::POS_W-1:0]          found_position
);

	localparam int LW    = $clog2(TABLE_DEPTH);
	localparam int NW    = LW + 1;
	localparam int NODES = 2 ** NW;
	localparam int XW    = ((LW + 1 > fpal_pkg::POS_W) ? LW + 1 : fpal_pkg::POS_W) + 1;

	// tree memory, node 1 is the root, leaves at N..2N-1
	fpal_pkg::node_t mem_q [NODES];
	fpal_pkg::node_t rd_data_q;
	fpal_pkg::node_t cur_q;
	fpal_pkg::node_t merged;
	fpal_pkg::node_t wr_data;

	logic [NW-1:0]                        node_q;
	logic [NW-1:0]                        clr_q;
	logic [NW-1:0]                        rd_addr;
	logic [NW-1:0]                        wr_addr;
	logic                                 rd_en;
	logic                                 wr_en;
	logic [fpal_pkg::POS_W-1:0]           size_q;
	logic                                 op_q;
	logic                                 range_ok_q;
	logic signed [fpal_pkg::VAL_W-1:0]    amt_q;
	logic                                 res_found_q;
	logic [fpal_pkg::POS_W-1:0]           res_pos_q;
	logic                                 found_q;
	logic [fpal_pkg::POS_W-1:0]           found_position_q;

	logic [XW-1:0] lim_x;
	logic [XW-1:0] size_x;
	logic [XW-1:0] pos_eff_x;
	logic [XW-1:0] off_x;
	logic [XW-1:0] leaf_pos_x;
	logic [NW-1:0] leaf_node;
	logic          qual;

	// usable limit is the smaller of size and depth
	always_comb begin
		size_x = XW'(size_q);
		lim_x  = (size_x < XW'(TABLE_DEPTH)) ? size_x : XW'(TABLE_DEPTH);
	end

	// incoming position: a search from zero starts at one
	always_comb begin
		if (opcode == fpal_pkg::OP_SEARCH && position == '0) begin
			pos_eff_x = XW'(1);
		end else begin
			pos_eff_x = XW'(position);
		end
		off_x     = pos_eff_x - XW'(1);
		leaf_node = {1'b1, off_x[LW-1:0]};
	end

	// position of the current leaf
	assign leaf_pos_x = XW'(node_q[LW-1:0]) + XW'(1);

	// threshold test on the word just read
	assign qual = rd_data_q.written && (rd_data_q.value >= amt_q);

	// parent record from the current node and its sibling
	always_comb begin
		merged = cur_q;
		if (!cur_q.written) begin
			merged = rd_data_q;
		end else if (rd_data_q.written && rd_data_q.value > cur_q.value) begin
			merged = rd_data_q;
		end
	end

	// memory port selects
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = node_q;
		wr_en   = 1'b0;
		wr_addr = node_q;
		wr_data = cur_q;
		case (cmd.op)
			fpal_pkg::DP_RD_SIB: begin
				rd_en   = 1'b1;
				rd_addr = node_q ^ NW'(1);
			end
			fpal_pkg::DP_RD_NODE: begin
				rd_en   = 1'b1;
				rd_addr = node_q;
			end
			fpal_pkg::DP_RD_NEXT: begin
				rd_en   = 1'b1;
				rd_addr = node_q + NW'(1);
			end
			fpal_pkg::DP_RD_LEFT: begin
				rd_en   = 1'b1;
				rd_addr = {node_q[NW-2:0], 1'b0};
			end
			fpal_pkg::DP_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			fpal_pkg::DP_WR_LEAF: begin
				wr_en         = 1'b1;
				wr_addr       = node_q;
				wr_data.written = 1'b1;
				wr_data.value   = amt_q;
			end
			fpal_pkg::DP_WR_PARENT: begin
				wr_en   = 1'b1;
				wr_addr = node_q >> 1;
				wr_data = merged;
			end
			default: begin
			end
		endcase
	end

	// tree memory write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// clearing sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.op == fpal_pkg::DP_CLEAR) begin
			clr_q <= clr_q + NW'(1);
		end
	end

	// size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= fpal_pkg::SIZE_RESET;
		end else if (write_enable) begin
			size_q <= write_data;
		end
	end

	// word registers and node walker
	always_ff @(posedge clk) begin
		case (cmd.op)
			fpal_pkg::DP_LOAD: begin
				op_q       <= opcode;
				amt_q      <= amount;
				node_q     <= leaf_node;
				range_ok_q <= (pos_eff_x != '0) && (pos_eff_x <= lim_x);
			end
			fpal_pkg::DP_WR_LEAF: begin
				cur_q.written <= 1'b1;
				cur_q.value   <= amt_q;
			end
			fpal_pkg::DP_WR_PARENT: begin
				cur_q  <= merged;
				node_q <= node_q >> 1;
			end
			fpal_pkg::DP_UP: begin
				node_q <= node_q >> 1;
			end
			fpal_pkg::DP_RD_NEXT: begin
				node_q <= node_q + NW'(1);
			end
			fpal_pkg::DP_DESCEND: begin
				node_q <= {node_q[NW-2:0], ~qual};
			end
			fpal_pkg::DP_SET_FOUND: begin
				res_found_q <= (leaf_pos_x <= lim_x);
				res_pos_q   <= (leaf_pos_x <= lim_x) ?
					fpal_pkg::POS_W'(leaf_pos_x) : '0;
			end
			fpal_pkg::DP_SET_NONE: begin
				res_found_q <= 1'b0;
				res_pos_q   <= '0;
			end
			default: begin
			end
		endcase
	end

	// output word register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			found_q          <= res_found_q;
			found_position_q <= res_pos_q;
		end
	end

	assign found          = found_q;
	assign found_position = found_position_q;

	// status back to the controller
	always_comb begin
		sts.clr_last  = &clr_q;
		sts.is_search = (op_q == fpal_pkg::OP_SEARCH);
		sts.range_ok  = range_ok_q;
		sts.at_root   = (node_q == NW'(1));
		sts.node_odd  = node_q[0];
		sts.at_leaf   = node_q[NW-1];
		sts.qualifies = qual;
	end

endmodule

>>> hdl/fpal_ctrl.sv
// controller: state machine sequencing tree updates, searches and the output word
module fpal_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	input  fpal_pkg::sts_t sts,
	output fpal_pkg::cmd_t cmd
);

	fpal_pkg::state_t state_q;
	fpal_pkg::state_t state_nxt;
	logic             out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fpal_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd.op    = fpal_pkg::DP_IDLE;
		cmd.emit  = 1'b0;
		unique case (state_q)
			fpal_pkg::ST_CLEAR: begin
				cmd.op = fpal_pkg::DP_CLEAR;
				if (sts.clr_last) begin
					state_nxt = fpal_pkg::ST_IDLE;
				end
			end
			fpal_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.op    = fpal_pkg::DP_LOAD;
					state_nxt = fpal_pkg::ST_DECIDE;
				end
			end
			fpal_pkg::ST_DECIDE: begin
				if (!sts.range_ok) begin
					if (sts.is_search) begin
						cmd.op    = fpal_pkg::DP_SET_NONE;
						state_nxt = fpal_pkg::ST_EMIT;
					end else begin
						state_nxt = fpal_pkg::ST_IDLE;
					end
				end else if (sts.is_search) begin
					cmd.op    = fpal_pkg::DP_RD_NODE;
					state_nxt = fpal_pkg::ST_S_CHECK;
				end else begin
					cmd.op    = fpal_pkg::DP_WR_LEAF;
					state_nxt = fpal_pkg::ST_W_UP;
				end
			end
			fpal_pkg::ST_W_UP: begin
				if (sts.at_root) begin
					state_nxt = fpal_pkg::ST_IDLE;
				end else begin
					cmd.op    = fpal_pkg::DP_RD_SIB;
					state_nxt = fpal_pkg::ST_W_MERGE;
				end
			end
			fpal_pkg::ST_W_MERGE: begin
				cmd.op    = fpal_pkg::DP_WR_PARENT;
				state_nxt = fpal_pkg::ST_W_UP;
			end
			fpal_pkg::ST_S_CHECK: begin
				if (sts.qualifies) begin
					state_nxt = fpal_pkg::ST_S_DOWN;
				end else begin
					state_nxt = fpal_pkg::ST_S_CLIMB;
				end
			end
			fpal_pkg::ST_S_CLIMB: begin
				if (sts.at_root) begin
					cmd.op    = fpal_pkg::DP_SET_NONE;
					state_nxt = fpal_pkg::ST_EMIT;
				end else if (sts.node_odd) begin
					cmd.op = fpal_pkg::DP_UP;
				end else begin
					cmd.op    = fpal_pkg::DP_RD_NEXT;
					state_nxt = fpal_pkg::ST_S_CHECK;
				end
			end
			fpal_pkg::ST_S_DOWN: begin
				if (sts.at_leaf) begin
					cmd.op    = fpal_pkg::DP_SET_FOUND;
					state_nxt = fpal_pkg::ST_EMIT;
				end else begin
					cmd.op    = fpal_pkg::DP_RD_LEFT;
					state_nxt = fpal_pkg::ST_S_DESC;
				end
			end
			fpal_pkg::ST_S_DESC: begin
				cmd.op    = fpal_pkg::DP_DESCEND;
				state_nxt = fpal_pkg::ST_S_DOWN;
			end
			fpal_pkg::ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.emit  = 1'b1;
					state_nxt = fpal_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = fpal_pkg::ST_IDLE;
			end
		endcase
	end

	// output word valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign in_stall  = (state_q != fpal_pkg::ST_IDLE);

endmodule

>>> hdl/first_position_at_least_search.sv
// top level of the first-position-at-least search block
// Keeps signed 32-bit values at positions 1..TABLE_DEPTH in a tree of maxima held in one
// single-port-read memory of 2*N words (N is TABLE_DEPTH rounded up to a power of two).
// After reset the block sweeps all 2*N words of that memory clean, one word a cycle
// (2048 words at the default depth), and holds in_stall high meanwhile; size writes
// are taken at any time. One word is worked at a time: a write stores the leaf, then
// does one sibling read and one parent write per tree level; a search that starts out
// of range reports no hit without reading the tree, else it climbs with one read per
// checked node, then descends with one read per level; the answer then moves into the
// output register. The tree memory's single read port sets this pace. A finished answer
// waits in the output register while the next input word is taken.
`include "assert_macros.svh"

module first_position_at_least_search #(
	parameter int TABLE_DEPTH = fpal_pkg::TABLE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              opcode,
	input  logic [fpal_pkg::POS_W-1:0]        position,
	input  logic signed [fpal_pkg::VAL_W-1:0] amount,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              found,
	output logic [fpal_pkg::POS_W-1:0]        found_position,
	input  logic                              write_enable,
	input  logic [fpal_pkg::POS_W-1:0]        write_data
);

	fpal_pkg::cmd_t cmd;
	fpal_pkg::sts_t sts;

	// sequencer
	fpal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// tree memory and registers
	fpal_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.opcode         (opcode),
		.position       (position),
		.amount         (amount),
		.write_enable   (write_enable),
		.write_data     (write_data),
		.found          (found),
		.found_position (found_position)
	);

	// one word at a time: an accepted word blocks the next cycle
	`FPAL_ASSERT_NEXT(a_accept_then_busy, in_valid && !in_stall, in_stall)
	// a miss reports position zero
	`FPAL_ASSERT_IMPL(a_miss_pos_zero, out_valid && !found, found_position == '0)
	// a hit never reports position zero
	`FPAL_ASSERT_IMPL(a_hit_pos_nonzero, out_valid && found, found_position != '0)

endmodule
